### rtl/core/ucu8_pkg.sv
package ucu8_pkg;

	localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
	localparam logic [7:0] CH_BSL  = 8'h5C;  // backslash
	localparam logic [7:0] CH_U    = 8'h75;  // 'u'
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;

	localparam logic [15:0] MAX_1B = 16'h007F;
	localparam logic [15:0] MAX_2B = 16'h07FF;
	localparam logic [7:0]  LEAD_2 = 8'hC0;
	localparam logic [7:0]  LEAD_3 = 8'hE0;
	localparam logic [7:0]  CONT   = 8'h80;

	localparam logic [2:0] HEX_LEN = 3'd4;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  cnt;
		logic [15:0] code;
		logic        stopped;
	} scan_t;

	// up to three output bytes from one input beat, slot 0 first
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
	} res_t;

	function automatic logic is_esc(logic [7:0] b);
		is_esc = (b == CH_PCT) || (b == CH_BSL);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		hex_digit = 5'b0;
		if (b >= CH_0 && b <= CH_9) begin
			t = b - CH_0;
			hex_digit = {1'b1, t[3:0]};
		end else if (b >= CH_LA && b <= CH_LF) begin
			t = b - CH_LA + 8'd10;
			hex_digit = {1'b1, t[3:0]};
		end else if (b >= CH_UA && b <= CH_UF) begin
			t = b - CH_UA + 8'd10;
			hex_digit = {1'b1, t[3:0]};
		end
	endfunction

	function automatic res_t encode_cp(logic [15:0] v);
		res_t r;
		r = '0;
		if (v <= MAX_1B) begin
			r.cnt      = 2'd1;
			r.bytes[0] = v[7:0];
		end else if (v <= MAX_2B) begin
			r.cnt      = 2'd2;
			r.bytes[0] = LEAD_2 | {3'b000, v[10:6]};
			r.bytes[1] = CONT | {2'b00, v[5:0]};
		end else begin
			r.cnt      = 2'd3;
			r.bytes[0] = LEAD_3 | {4'b0000, v[15:12]};
			r.bytes[1] = CONT | {2'b00, v[11:6]};
			r.bytes[2] = CONT | {2'b00, v[5:0]};
		end
		encode_cp = r;
	endfunction

endpackage

### rtl/core/ucu8_in_if.sv
interface ucu8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/core/ucu8_out_if.sv
interface ucu8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

### rtl/core/ucu8_decode.sv
module ucu8_decode
	import ucu8_pkg::*;
(
	input  scan_t      st,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output scan_t      st_nx,
	output res_t       res
);

	logic [4:0] hd;

	always_comb begin
		st_nx = st;
		res   = '0;
		hd    = hex_digit(in_byte);

		case (st.mode)
			MODE_ESC: begin
				if (in_byte == CH_U) begin
					st_nx.mode    = MODE_HEX;
					st_nx.cnt     = 3'd0;
					st_nx.code    = 16'h0000;
					st_nx.stopped = 1'b0;
				end else begin
					// escape without 'u' always shows as '%'
					res.bytes[0] = CH_PCT;
					if (is_esc(in_byte)) begin
						st_nx.mode = MODE_ESC;
						res.cnt    = 2'd1;
					end else begin
						st_nx.mode   = MODE_PASS;
						res.bytes[1] = in_byte;
						res.cnt      = 2'd2;
					end
				end
			end
			MODE_HEX: begin
				if (!st.stopped && hd[4])
					st_nx.code = {st.code[11:0], hd[3:0]};
				else
					st_nx.stopped = 1'b1;
				st_nx.cnt = st.cnt + 3'd1;
				if (st_nx.cnt >= HEX_LEN) begin
					res   = encode_cp(st_nx.code);
					st_nx = '0;
				end
			end
			default: begin
				st_nx.mode = MODE_PASS;
				if (is_esc(in_byte)) begin
					st_nx.mode = MODE_ESC;
				end else begin
					res.bytes[0] = in_byte;
					res.cnt      = 2'd1;
				end
			end
		endcase

		// end of stream: flush a pending escape or partial code
		if (in_last) begin
			if (st_nx.mode == MODE_ESC) begin
				res.bytes[res.cnt] = CH_PCT;
				res.cnt            = res.cnt + 2'd1;
			end else if (st_nx.mode == MODE_HEX) begin
				res = encode_cp(st_nx.code);
			end
			res.last = 1'b1;
			st_nx    = '0;
		end
	end

endmodule

### rtl/core/ucu8_outbuf.sv
module ucu8_outbuf
	import ucu8_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  res_t  res,
	output logic  can_load,
	ucu8_out_if.source out_ch
);

	logic [1:0]      cnt_q;
	logic [2:0][7:0] bytes_q;
	logic            last_q;
	logic            pop;

	assign pop      = out_ch.valid && out_ch.ready;
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ch.ready);

	assign out_ch.valid    = (cnt_q != 2'd0);
	assign out_ch.out_byte = bytes_q[0];
	assign out_ch.out_last = last_q && (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= res.cnt;
			last_q <= res.last;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// shift toward slot 0 as beats leave
	always_ff @(posedge clk) begin
		if (load)
			bytes_q <= res.bytes;
		else if (pop)
			bytes_q <= {8'h00, bytes_q[2:1]};
	end

endmodule

### rtl/core/unicode_escape_to_utf8.sv
// Percent-u / backslash-u escape decoder with UTF-8 output.
//
// in_ch carries one text byte per beat (in_byte, in_last marks the end of
// the stream). out_ch carries one output byte per beat; out_last is set on
// the final byte produced for the beat that had in_last.
//
// An input beat lands in an input register, then one pass of decode logic
// updates the scan state and loads 0 to 3 result bytes into a small shift
// buffer that drains one byte per cycle while the receiver is ready. A
// beat's first output byte appears once the buffer has loaded its bytes.
//
// Throughput: one input beat per cycle while the buffer keeps up. A beat
// waits in the input register while its predecessor's bytes still drain,
// so a 3-byte code point holds input back; the escape that produced it
// took six input beats.
//
// Reset clears the scan state and empties the input register and buffer.
// When the receiver stalls, the buffer holds, the input register fills,
// and in_ch ready drops until the buffer can take the next beat's bytes.
module unicode_escape_to_utf8
	import ucu8_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ucu8_in_if.sink    in_ch,
	ucu8_out_if.source out_ch
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	scan_t scan_q;
	scan_t scan_nx;
	res_t  dec_res;
	logic  can_load;
	logic  advance;
	logic  in_take;

	assign advance     = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || can_load;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// scan state moves only when a beat's bytes go into the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scan_q <= '0;
		else if (advance)
			scan_q <= scan_nx;
	end

	ucu8_decode u_decode (
		.st      (scan_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.st_nx   (scan_nx),
		.res     (dec_res)
	);

	ucu8_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (dec_res),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

`ifndef SYNTHESIS
	// end of stream leaves the scanner in its idle state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (scan_q == '0))
		else $error("scan state not cleared after last beat");

	// a final beat must produce a byte to carry out_last
	a_last_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> (dec_res.cnt != 2'd0))
		else $error("last beat produced no output");

	// stored digit count never reaches the code length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q.cnt < HEX_LEN)
		else $error("digit count out of range");

	// a new beat is never accepted while the input register is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_load) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register overrun");
`endif

endmodule

### sim/tb_unicode_escape_to_utf8.sv
module tb_unicode_escape_to_utf8;
	import ucu8_pkg::*;

	// cycles with no beat on either side before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	// drain margin after the last expected byte
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} utf8_beat_t;

	logic clk;
	logic arst_n;

	ucu8_in_if  in_ch ();
	ucu8_out_if out_ch ();

	unicode_escape_to_utf8 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// decoder state as the testbench sees it
	mode_t       scan_mode;
	logic [2:0]  hex_taken;
	logic [15:0] code_point;
	logic        hex_done;

	logic [7:0]  step_bytes[$];   // bytes produced by the beat under prediction
	utf8_beat_t  utf8_pending[$]; // expected output beats, oldest first

	int mismatches;
	int quiet_cycles;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	// 1..3 byte UTF-8 form of a 16-bit code point; surrogates go out as is
	function automatic void emit_utf8(logic [15:0] cp);
		if (cp <= 16'h007F) begin
			step_bytes.push_back(cp[7:0]);
		end else if (cp <= 16'h07FF) begin
			step_bytes.push_back({3'b110, cp[10:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			step_bytes.push_back({4'b1110, cp[15:12]});
			step_bytes.push_back({2'b10, cp[11:6]});
			step_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void clear_scan();
		scan_mode  = MODE_PASS;
		hex_taken  = '0;
		code_point = '0;
		hex_done   = 1'b0;
	endfunction

	function automatic void take_plain(logic [7:0] c);
		if (c == CH_PCT || c == CH_BSL)
			scan_mode = MODE_ESC;
		else
			step_bytes.push_back(c);
	endfunction

	function automatic void predict_beat(logic [7:0] c, logic fin);
		int nib;
		int i;
		step_bytes.delete();
		case (scan_mode)
			MODE_ESC: begin
				if (c == CH_U) begin
					scan_mode  = MODE_HEX;
					hex_taken  = '0;
					code_point = '0;
					hex_done   = 1'b0;
				end else begin
					// escape without 'u' always comes out as '%'
					step_bytes.push_back(CH_PCT);
					scan_mode = MODE_PASS;
					take_plain(c);
				end
			end
			MODE_HEX: begin
				nib = hex_nibble(c);
				if (!hex_done && nib >= 0)
					code_point = {code_point[11:0], 4'(nib)};
				else
					hex_done = 1'b1;
				hex_taken = hex_taken + 3'd1;
				if (hex_taken >= HEX_LEN) begin
					emit_utf8(code_point);
					clear_scan();
				end
			end
			default: begin
				scan_mode = MODE_PASS;
				take_plain(c);
			end
		endcase
		if (fin) begin
			// flush whatever is pending at end of stream
			if (scan_mode == MODE_ESC)
				step_bytes.push_back(CH_PCT);
			else if (scan_mode == MODE_HEX)
				emit_utf8(code_point);
			clear_scan();
		end
		for (i = 0; i < step_bytes.size(); i++)
			utf8_pending.push_back('{data: step_bytes[i],
				last: fin && (i == step_bytes.size() - 1)});
	endfunction

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted input beat, checks every output
	// beat against the oldest expectation, and watches for a hang.
	// Input side is handled first so nothing depends on process order.
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("[%0t] mismatch: %s got %02h want %02h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (in_ch.valid && in_ch.ready) begin
				predict_beat(in_ch.in_byte, in_ch.in_last);
				quiet_cycles = 0;
			end
			if (out_ch.valid && out_ch.ready) begin
				quiet_cycles = 0;
				if (utf8_pending.size() == 0) begin
					report_mismatch("unexpected out beat", out_ch.out_byte, 8'h00);
				end else begin
					if (out_ch.out_byte !== utf8_pending[0].data)
						report_mismatch("out_byte", out_ch.out_byte,
							utf8_pending[0].data);
					if (out_ch.out_last !== utf8_pending[0].last)
						report_mismatch("out_last", {7'd0, out_ch.out_last},
							{7'd0, utf8_pending[0].last});
					void'(utf8_pending.pop_front());
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[%0t] no beat for %0d cycles, %0d bytes outstanding",
					$time, quiet_cycles, utf8_pending.size());
				$display("unicode_escape_to_utf8 verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a long hold-off counted down here
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ch.ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// one input beat; returns at the rising edge where it is taken
	task automatic send_byte(input logic [7:0] c, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= c;
		in_ch.in_last <= fin;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic send_text(input string s, input bit fin);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], fin && (i == s.len() - 1));
	endtask

	task automatic park_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// nothing left in flight: all predicted bytes seen, then a short margin
	task automatic wait_drained();
		park_input();
		while (utf8_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex_char();
		case ($urandom_range(2))
			0: return 8'("0" + $urandom_range(9));
			1: return 8'("a" + $urandom_range(5));
			default: return 8'("A" + $urandom_range(5));
		endcase
	endfunction

	// Mostly complete escapes with random digits, the rest plain bytes,
	// broken escapes, and streams cut short in the middle of an escape.
	task automatic send_random_traffic(input int n_items);
		logic [7:0] seq[$];
		int sent;
		int kind;
		int lead0;
		int i;
		bit fin;
		sent = 0;
		while (sent < n_items) begin
			seq.delete();
			fin  = ($urandom_range(7) == 0);
			kind = $urandom_range(99);
			if (kind < 55) begin
				seq.push_back($urandom_range(1) ? CH_PCT : CH_BSL);
				seq.push_back(CH_U);
				lead0 = $urandom_range(2);  // bias toward 1- and 2-byte codes
				for (i = 0; i < 4; i++) begin
					if (i < lead0)
						seq.push_back("0");
					else if ($urandom_range(99) < 85)
						seq.push_back(rand_hex_char());
					else
						seq.push_back(8'($urandom_range(255)));
				end
				// cut the stream short inside the escape now and then
				if ($urandom_range(9) == 0) begin
					seq = seq[0:$urandom_range(5)];
					fin = 1'b1;
				end
			end else if (kind < 85) begin
				seq.push_back(8'($urandom_range(255)));
			end else begin
				seq.push_back($urandom_range(1) ? CH_PCT : CH_BSL);
				do
					seq.push_back(8'($urandom_range(255)));
				while (seq[$] == CH_U && seq.size() == 2 && seq.pop_back() >= 0);
			end
			for (i = 0; i < seq.size(); i++)
				send_byte(seq[i], fin && (i == seq.size() - 1));
			sent += seq.size();
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// 1-, 2- and 3-byte codes, surrogate, early stop, stray escape
	task automatic test_directed_escapes();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_byte(8'h00, 1'b0);
		send_text("%u0041", 1'b0);
		send_text("\\ud800", 1'b0);
		send_text("%u7FFg", 1'b0);     // digits stop at 'g', code 7FF
		send_byte(CH_BSL, 1'b0);       // backslash without u emits '%'
		send_byte(8'hFF, 1'b0);
		wait_drained();
	endtask

	// escape after escape, no digits with partial code at end, lone escape
	task automatic test_end_of_stream();
		send_text("\\%uG", 1'b1);
		send_text("%", 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int tx_idle, input int rx_stall,
		input int n_items);
		tx_idle_pct  = tx_idle;
		rx_stall_pct = rx_stall;
		send_random_traffic(n_items);
		wait_drained();
	endtask

	// receiver holds off long enough for the block to back up its input
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = HOLD_CYCLES;
		send_random_traffic(40);
		wait_drained();
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		out_ch.ready  = 1'b0;
		mismatches    = 0;
		quiet_cycles  = 0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		rx_hold       = 0;
		clear_scan();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_escapes();
		test_end_of_stream();
		test_random_traffic(0, 0, 65);
		test_random_traffic(50, 0, 65);
		test_random_traffic(0, 50, 65);
		test_random_traffic(26, 26, 65);
		test_backpressure();

		if (mismatches == 0) begin
			$display("unicode_escape_to_utf8 verification clean");
		end else begin
			$display("unicode_escape_to_utf8 verification failed");
		end
		$finish;
	end

endmodule

### unicode_escape_to_utf8.f
rtl/core/ucu8_pkg.sv
rtl/core/ucu8_in_if.sv
rtl/core/ucu8_out_if.sv
rtl/core/ucu8_decode.sv
rtl/core/ucu8_outbuf.sv
rtl/core/unicode_escape_to_utf8.sv
sim/tb_unicode_escape_to_utf8.sv
